FILE: rtl/ffca_pkg.sv
// Shared types and constants of the first-fit contiguous allocator.
// Used by the channel interfaces, the scan engine, the top level and the assertion module.
package ffca_pkg;

  localparam int KIND_W  = 1;
  localparam int COUNT_W = 11;
  localparam int START_W = 10;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] unit_count;
    logic [START_W-1:0] release_start;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] run_start;
  } res_t;

endpackage

FILE: rtl/ffca_if.sv
// Valid/ready channels of the allocator: the request channel and the result channel.
// Depends on ffca_pkg for the field widths.
interface ffca_req_if;
  logic                          valid;
  logic                          ready;
  logic [ffca_pkg::KIND_W-1:0]   kind;
  logic [ffca_pkg::COUNT_W-1:0]  unit_count;
  logic [ffca_pkg::START_W-1:0]  release_start;

  modport source (output valid, kind, unit_count, release_start, input ready);
  modport sink   (input valid, kind, unit_count, release_start, output ready);
  modport mon    (input valid, ready, kind, unit_count, release_start);
endinterface

interface ffca_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [ffca_pkg::START_W-1:0]  run_start;

  modport source (output valid, granted, run_start, input ready);
  modport sink   (input valid, granted, run_start, output ready);
  modport mon    (input valid, ready, granted, run_start);
endinterface

FILE: rtl/first_fit_contiguous_allocator.sv
// First-fit contiguous allocator over a one-bit-per-unit bitmap memory. The scan reads the
// bitmap one unit per cycle from unit 0 until a run is found or the map ends, then the claim
// writes one unit per cycle. An allocate that finds no run scans the whole map; a free
// writes the n units it names, clipped at the end of memory; a zero-size or oversized
// allocate and an out-of-range free go straight to their result without touching the
// bitmap. One request is in flight at a time; its result sits in an output register so the
// next request is taken while the previous result waits. After reset a clearing pass writes
// every unit free, during which no request is accepted.
// Depends on ffca_pkg, ffca_if and ffca_engine.
module first_fit_contiguous_allocator #(
  parameter int MEMORY_UNITS = 1024
) (
  input logic        clk,
  input logic        rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp
);

  ffca_pkg::req_t req_s;
  ffca_pkg::res_t eng_res;
  logic           eng_res_valid;
  logic           eng_res_ready;
  logic           rsp_valid;
  ffca_pkg::res_t rsp_r;

  assign req_s.kind          = req.kind;
  assign req_s.unit_count    = req.unit_count;
  assign req_s.release_start = req.release_start;

  ffca_engine #(
    .MEMORY_UNITS(MEMORY_UNITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .req      (req_s),
    .res_valid(eng_res_valid),
    .res_ready(eng_res_ready),
    .res      (eng_res)
  );

  assign eng_res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_res_ready) begin
      rsp_valid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ready && eng_res_valid) begin
      rsp_r <= eng_res;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.granted   = rsp_r.granted;
  assign rsp.run_start = rsp_r.run_start;

endmodule

FILE: rtl/ffca_engine.sv
// Scan engine: owns the used/free bitmap memory (one bit per unit, registered read)
// and the sequencer for the clearing pass, first-fit scan, claim and release. Depends on ffca_pkg.
module ffca_engine #(
  parameter int MEMORY_UNITS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffca_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output ffca_pkg::res_t res
);

  localparam int AW = $clog2(MEMORY_UNITS);
  localparam int CW = $clog2(MEMORY_UNITS + 1);

  localparam logic [CW-1:0] UNITS_C = CW'(MEMORY_UNITS);
  localparam logic [CW-1:0] LAST_C  = CW'(MEMORY_UNITS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                   state;
  logic [CW-1:0]                scan_addr;
  logic [CW-1:0]                rd_unit;
  logic                         rd_pending;
  logic [CW-1:0]                run_len;
  logic [CW-1:0]                size_r;
  logic [AW-1:0]                run_begin;
  logic [CW-1:0]                fill_addr;
  logic [ffca_pkg::COUNT_W-1:0] remaining;
  logic                         fill_val;
  ffca_pkg::res_t               res_r;

  logic                         used_mem [MEMORY_UNITS];
  logic                         rd_data;

  logic                         scan_issue;
  logic                         fill_busy;
  logic                         mem_we;
  logic                         mem_wd;
  logic [CW-1:0]                run_len_inc;
  logic                         hit;
  logic [AW-1:0]                hit_begin;

  assign scan_issue  = (state == ST_SCAN) && (scan_addr != UNITS_C);
  assign fill_busy   = (state == ST_FILL) && (remaining != '0) && (fill_addr != UNITS_C);
  assign mem_we      = (state == ST_CLEAR) || fill_busy;
  assign mem_wd      = (state == ST_FILL) ? fill_val : 1'b0;
  assign run_len_inc = run_len + 1'b1;
  assign hit         = rd_pending && !rd_data && (run_len_inc == size_r);
  assign hit_begin   = (run_len == '0) ? rd_unit[AW-1:0] : run_begin;

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[fill_addr[AW-1:0]] <= mem_wd;
    end
    if (scan_issue) begin
      rd_data <= used_mem[scan_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      fill_addr  <= '0;
      rd_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == LAST_C) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            res_r      <= '0;
            remaining  <= req.unit_count;
            scan_addr  <= '0;
            run_len    <= '0;
            rd_pending <= 1'b0;
            size_r     <= CW'(req.unit_count);
            fill_val   <= 1'b0;
            if (req.kind == ffca_pkg::KIND_ALLOC) begin
              if ((req.unit_count == '0) ||
                  (32'(req.unit_count) > 32'(MEMORY_UNITS))) begin
                state <= ST_DONE;
              end else begin
                state <= ST_SCAN;
              end
            end else begin
              if (32'(req.release_start) >= 32'(MEMORY_UNITS)) begin
                state <= ST_DONE;
              end else begin
                fill_addr <= CW'(req.release_start);
                state     <= ST_FILL;
              end
            end
          end
        end
        ST_SCAN: begin
          rd_pending <= scan_issue;
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
            rd_unit   <= scan_addr;
          end
          if (rd_pending) begin
            if (rd_data) begin
              run_len <= '0;
            end else begin
              if (run_len == '0) begin
                run_begin <= rd_unit[AW-1:0];
              end
              run_len <= run_len_inc;
            end
          end
          if (hit) begin
            fill_addr         <= CW'(hit_begin);
            fill_val          <= 1'b1;
            res_r.granted     <= 1'b1;
            res_r.run_start   <= ffca_pkg::START_W'(hit_begin);
            state             <= ST_FILL;
          end else if (!rd_pending && !scan_issue) begin
            state <= ST_DONE;
          end
        end
        ST_FILL: begin
          if (fill_busy) begin
            fill_addr <= fill_addr + 1'b1;
            remaining <= remaining - 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/ffca_assert.sv
// Port-level assertions for the first-fit contiguous allocator, bound to the top level.
// Depends on ffca_pkg.
module ffca_assert (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [ffca_pkg::KIND_W-1:0]  req_kind,
  input logic [ffca_pkg::COUNT_W-1:0] req_unit_count,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_granted,
  input logic [ffca_pkg::START_W-1:0] rsp_run_start
);

  a_fail_start_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_granted) |-> (rsp_run_start == '0))
    else $error("failed or free beat carries a nonzero run_start");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a request is still in work");

  a_zero_size_fails: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req_kind == ffca_pkg::KIND_ALLOC) &&
     (req_unit_count == '0) && !rsp_valid)
    |=> ##1 (rsp_valid && !rsp_granted))
    else $error("zero-size allocate did not fail promptly");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
    (rsp_valid && $stable(rsp_granted) && $stable(rsp_run_start)))
    else $error("stalled result beat changed");

endmodule

bind first_fit_contiguous_allocator ffca_assert u_ffca_assert (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_kind      (req.kind),
  .req_unit_count(req.unit_count),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_granted   (rsp.granted),
  .rsp_run_start (rsp.run_start)
);
